### hw/rtl/spdn_pkg.sv
package spdn_pkg;

  // Field and datapath widths
  localparam int COORD_WIDTH     = 24;
  localparam int ACC_WIDTH       = 48;
  localparam int FRAC_SHIFT      = 24;
  localparam int H2_WIDTH        = 48;
  localparam int COEFF_WIDTH     = 32;
  localparam int MASS_WIDTH      = 32;
  localparam int X_WIDTH         = 32;
  localparam int X_SHIFT         = 8;
  localparam int OUT_WIDTH       = 48;
  localparam int NUM_COMP        = 3;
  localparam int COMP_IDX_WIDTH  = $clog2(NUM_COMP);

  // Serial multiplier: A operand parallel, B operand consumed one bit per cycle
  localparam int MUL_A_WIDTH     = ACC_WIDTH;
  localparam int MUL_B_WIDTH     = 32;
  localparam int PROD_WIDTH      = MUL_A_WIDTH + MUL_B_WIDTH;
  localparam int MUL_CNT_WIDTH   = $clog2(MUL_B_WIDTH);

  // Squared distance: three exact squares
  localparam int SQ_WIDTH        = 2 * COORD_WIDTH;
  localparam int D2_WIDTH        = SQ_WIDTH + 2;
  localparam int CMP_WIDTH       = (D2_WIDTH > H2_WIDTH) ? D2_WIDTH : H2_WIDTH;

  // Stream and config port widths
  localparam int IN_DATA_WIDTH   = ((NUM_COMP * COORD_WIDTH + 7) / 8) * 8;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 48;

  // Register reset values
  localparam logic [H2_WIDTH-1:0]    H2_RESET    = H2_WIDTH'(64'h1_0000_0000);
  localparam logic [COEFF_WIDTH-1:0] COEFF_RESET = COEFF_WIDTH'(26284786);
  localparam logic [MASS_WIDTH-1:0]  MASS_RESET  = MASS_WIDTH'(32'h0100_0000);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_H_SQUARED     = 2'd0,
    REG_KERNEL_COEFF  = 2'd1,
    REG_PARTICLE_MASS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [H2_WIDTH-1:0]    h_squared;
    logic [COEFF_WIDTH-1:0] kernel_coeff;
    logic [MASS_WIDTH-1:0]  particle_mass;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XPREP,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_ACC,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_END,
    ST_DENS_GO,
    ST_DENS_WAIT
  } state_t;

  typedef enum logic [1:0] {
    STG_X2,
    STG_X3,
    STG_TERM
  } stage_t;

  typedef struct packed {
    logic [ACC_WIDTH-1:0] value;
    logic                 sat;
  } acc_sat_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] value;
    logic                 sat;
  } out_sat_t;

  // (a*b) >> FRAC_SHIFT, saturated at the accumulator maximum
  function automatic acc_sat_t shift_sat(input logic [PROD_WIDTH-1:0] prod);
    acc_sat_t r;
    r.sat   = |prod[PROD_WIDTH-1:FRAC_SHIFT+ACC_WIDTH];
    r.value = r.sat ? '1 : prod[FRAC_SHIFT +: ACC_WIDTH];
    return r;
  endfunction

  // Clip an accumulator-wide value to the output width
  function automatic out_sat_t out_clip(input acc_sat_t a);
    out_sat_t r;
    logic     over;
    over = 1'b0;
    for (int i = OUT_WIDTH; i < ACC_WIDTH; i++) begin
      over = over | a.value[i];
    end
    r.sat   = a.sat | over;
    r.value = over ? '1 : OUT_WIDTH'(a.value);
    return r;
  endfunction

  // Magnitude of a two's complement coordinate; the most negative value maps to 2^(W-1)
  function automatic logic [COORD_WIDTH-1:0] coord_mag(input logic [COORD_WIDTH-1:0] c);
    return c[COORD_WIDTH-1] ? (~c + 1'b1) : c;
  endfunction

endpackage

### hw/rtl/spdn_serial_mul.sv
// Bit-serial shift-add multiplier, LSB of b first, one bit per cycle
module spdn_serial_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [spdn_pkg::MUL_A_WIDTH-1:0]   a,
  input  logic [spdn_pkg::MUL_B_WIDTH-1:0]   b,
  output logic                               done,
  output logic [spdn_pkg::PROD_WIDTH-1:0]    prod
);

  logic                              busy;
  logic [spdn_pkg::MUL_CNT_WIDTH-1:0] cnt;
  logic [spdn_pkg::MUL_A_WIDTH-1:0]  a_q;
  logic [spdn_pkg::MUL_B_WIDTH-1:0]  b_q;
  logic [spdn_pkg::MUL_A_WIDTH-1:0]  hi;
  logic [spdn_pkg::MUL_B_WIDTH-1:0]  lo;
  logic [spdn_pkg::MUL_A_WIDTH:0]    step;

  assign step = {1'b0, hi} + (b_q[0] ? {1'b0, a_q} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_q  <= a;
        b_q  <= b;
        hi   <= '0;
        lo   <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        hi  <= step[spdn_pkg::MUL_A_WIDTH:1];
        lo  <= {step[0], lo[spdn_pkg::MUL_B_WIDTH-1:1]};
        b_q <= b_q >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == spdn_pkg::MUL_CNT_WIDTH'(spdn_pkg::MUL_B_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/spdn_cfg_regs.sv
// Kernel configuration registers; unknown indexes are dropped
module spdn_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [spdn_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [spdn_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  output spdn_pkg::cfg_t                        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.h_squared     <= spdn_pkg::H2_RESET;
      cfg.kernel_coeff  <= spdn_pkg::COEFF_RESET;
      cfg.particle_mass <= spdn_pkg::MASS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        spdn_pkg::REG_H_SQUARED: begin
          cfg.h_squared <= cfg_data[spdn_pkg::H2_WIDTH-1:0];
        end
        spdn_pkg::REG_KERNEL_COEFF: begin
          cfg.kernel_coeff <= cfg_data[spdn_pkg::COEFF_WIDTH-1:0];
        end
        spdn_pkg::REG_PARTICLE_MASS: begin
          cfg.particle_mass <= cfg_data[spdn_pkg::MASS_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/sph_poly6_density_sum_core.sv
// Sequence: every product runs on the one bit-serial multiplier, one product after another.
// Non-skip item: three squares, then x^2, x^3 and coeff*x^3 (the last three only if x > 0).
// Skip item: no products. A run's first item adds the self term first (x^2, x^3, coeff*x^3 if x > 0).
// Last item adds mass*sum, after any wait for the previous density beat to drain.
// Throughput: one item at a time, next beat taken when the sequencer returns to idle.
// Reset (rst, synchronous, active high): registers to defaults, no run open, output empty.
module sph_poly6_density_sum_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // neighbor displacement stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [spdn_pkg::IN_DATA_WIDTH-1:0]    s_tdata,   // dx, dy, dz (signed Q8.16)
  input  logic                                  s_tuser,   // skip
  input  logic                                  s_tlast,   // last neighbor of this particle
  // density result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [spdn_pkg::OUT_WIDTH-1:0]        m_tdata,   // density (unsigned Q24.24)
  output logic                                  m_tuser,   // saturated
  // config write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [spdn_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [spdn_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  spdn_pkg::cfg_t cfg;

  spdn_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // ---------------------------------------------------------------------------
  // Shared serial multiplier. Every product of the item goes through it:
  // |dx|^2, |dy|^2, |dz|^2, x*x, x^2*x, coeff*x^3 and at run end mass*sum.
  // ---------------------------------------------------------------------------
  logic                              mul_start;
  logic [spdn_pkg::MUL_A_WIDTH-1:0]  mul_a;
  logic [spdn_pkg::MUL_B_WIDTH-1:0]  mul_b;
  logic                              mul_done;
  logic [spdn_pkg::PROD_WIDTH-1:0]   mul_prod;

  spdn_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and run state
  // ---------------------------------------------------------------------------
  spdn_pkg::state_t state;
  spdn_pkg::state_t state_next;
  spdn_pkg::stage_t stage;

  logic [spdn_pkg::COORD_WIDTH-1:0]    comp [spdn_pkg::NUM_COMP];
  logic [spdn_pkg::COMP_IDX_WIDTH-1:0] comp_idx;
  logic                                skip_q;
  logic                                last_q;
  logic                                self_q;    // working on the self term
  logic                                run_open;
  logic                                sat_seen;
  logic                                term_sat;  // saturation inside the current term
  logic [spdn_pkg::ACC_WIDTH-1:0]      kernel_sum;
  logic [spdn_pkg::ACC_WIDTH-1:0]      v_q;       // x^2, then x^3, then the term
  logic [spdn_pkg::X_WIDTH-1:0]        x_q;
  logic [spdn_pkg::D2_WIDTH-1:0]       d2;

  // x = (h2 - d2) >> 8, clipped to 32 bits; only valid when h2 > d2.
  // The self term goes through the same path with d2 held at zero.
  logic [spdn_pkg::CMP_WIDTH-1:0] h2_ext;
  logic [spdn_pkg::CMP_WIDTH-1:0] d2_ext;
  logic [spdn_pkg::CMP_WIDTH-1:0] diff;
  logic                           x_pos;
  logic                           x_over;
  logic [spdn_pkg::X_WIDTH-1:0]   x_val;

  assign h2_ext = spdn_pkg::CMP_WIDTH'(cfg.h_squared);
  assign d2_ext = spdn_pkg::CMP_WIDTH'(d2);
  assign x_pos  = h2_ext > d2_ext;
  assign diff   = h2_ext - d2_ext;
  assign x_over = |diff[spdn_pkg::CMP_WIDTH-1:spdn_pkg::X_SHIFT+spdn_pkg::X_WIDTH];
  assign x_val  = x_over ? '1 : diff[spdn_pkg::X_SHIFT +: spdn_pkg::X_WIDTH];

  // Product post-processing: shift by the fraction, saturate
  spdn_pkg::acc_sat_t ms;
  spdn_pkg::out_sat_t dens;

  assign ms   = spdn_pkg::shift_sat(mul_prod);
  assign dens = spdn_pkg::out_clip(ms);

  // Saturating accumulate
  logic [spdn_pkg::ACC_WIDTH:0] acc_sum;
  logic                         acc_ovf;

  assign acc_sum = {1'b0, kernel_sum} + {1'b0, v_q};
  assign acc_ovf = acc_sum[spdn_pkg::ACC_WIDTH];

  logic [spdn_pkg::COORD_WIDTH-1:0] mag_sel;

  assign mag_sel = spdn_pkg::coord_mag(comp[comp_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spdn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, input ready and multiplier operands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      spdn_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (!run_open) begin
            state_next = spdn_pkg::ST_XPREP;
          end else if (!s_tuser) begin
            state_next = spdn_pkg::ST_SQ_GO;
          end else begin
            state_next = spdn_pkg::ST_END;
          end
        end
      end
      spdn_pkg::ST_XPREP: begin
        state_next = x_pos ? spdn_pkg::ST_MUL_GO : spdn_pkg::ST_ACC;
      end
      spdn_pkg::ST_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = spdn_pkg::ST_MUL_WAIT;
        case (stage)
          spdn_pkg::STG_X2: begin
            mul_a = spdn_pkg::MUL_A_WIDTH'(x_q);
            mul_b = spdn_pkg::MUL_B_WIDTH'(x_q);
          end
          spdn_pkg::STG_X3: begin
            mul_a = v_q;
            mul_b = spdn_pkg::MUL_B_WIDTH'(x_q);
          end
          default: begin
            mul_a = v_q;
            mul_b = spdn_pkg::MUL_B_WIDTH'(cfg.kernel_coeff);
          end
        endcase
      end
      spdn_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          state_next = (stage == spdn_pkg::STG_TERM) ? spdn_pkg::ST_ACC : spdn_pkg::ST_MUL_GO;
        end
      end
      spdn_pkg::ST_ACC: begin
        state_next = (self_q && !skip_q) ? spdn_pkg::ST_SQ_GO : spdn_pkg::ST_END;
      end
      spdn_pkg::ST_SQ_GO: begin
        mul_start  = 1'b1;
        mul_a      = spdn_pkg::MUL_A_WIDTH'(mag_sel);
        mul_b      = spdn_pkg::MUL_B_WIDTH'(mag_sel);
        state_next = spdn_pkg::ST_SQ_WAIT;
      end
      spdn_pkg::ST_SQ_WAIT: begin
        if (mul_done) begin
          if (comp_idx == spdn_pkg::COMP_IDX_WIDTH'(spdn_pkg::NUM_COMP - 1)) begin
            state_next = spdn_pkg::ST_XPREP;
          end else begin
            state_next = spdn_pkg::ST_SQ_GO;
          end
        end
      end
      spdn_pkg::ST_END: begin
        state_next = last_q ? spdn_pkg::ST_DENS_GO : spdn_pkg::ST_IDLE;
      end
      spdn_pkg::ST_DENS_GO: begin
        // the result goes straight to the output register, so wait for it to drain
        if (!m_tvalid) begin
          mul_start  = 1'b1;
          mul_a      = kernel_sum;
          mul_b      = spdn_pkg::MUL_B_WIDTH'(cfg.particle_mass);
          state_next = spdn_pkg::ST_DENS_WAIT;
        end
      end
      spdn_pkg::ST_DENS_WAIT: begin
        if (mul_done) begin
          state_next = spdn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spdn_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open   <= 1'b0;
      sat_seen   <= 1'b0;
      kernel_sum <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        spdn_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < spdn_pkg::NUM_COMP; i++) begin
              comp[i] <= s_tdata[i*spdn_pkg::COORD_WIDTH +: spdn_pkg::COORD_WIDTH];
            end
            skip_q   <= s_tuser;
            last_q   <= s_tlast;
            self_q   <= !run_open;
            d2       <= '0;
            comp_idx <= '0;
          end
        end
        spdn_pkg::ST_XPREP: begin
          stage    <= spdn_pkg::STG_X2;
          x_q      <= x_val;
          term_sat <= x_pos & x_over;
          if (!x_pos) begin
            v_q <= '0;
          end
        end
        spdn_pkg::ST_MUL_WAIT: begin
          if (mul_done) begin
            v_q      <= ms.value;
            term_sat <= term_sat | ms.sat;
            case (stage)
              spdn_pkg::STG_X2: stage <= spdn_pkg::STG_X3;
              spdn_pkg::STG_X3: stage <= spdn_pkg::STG_TERM;
              default:          stage <= spdn_pkg::STG_TERM;
            endcase
          end
        end
        spdn_pkg::ST_ACC: begin
          if (self_q) begin
            // self term opens the run
            kernel_sum <= v_q;
            sat_seen   <= term_sat;
            run_open   <= 1'b1;
            self_q     <= 1'b0;
            d2         <= '0;
            comp_idx   <= '0;
          end else begin
            kernel_sum <= acc_ovf ? '1 : acc_sum[spdn_pkg::ACC_WIDTH-1:0];
            sat_seen   <= sat_seen | term_sat | acc_ovf;
          end
        end
        spdn_pkg::ST_SQ_WAIT: begin
          if (mul_done) begin
            d2       <= d2 + spdn_pkg::D2_WIDTH'(mul_prod[spdn_pkg::SQ_WIDTH-1:0]);
            comp_idx <= comp_idx + 1'b1;
          end
        end
        spdn_pkg::ST_DENS_WAIT: begin
          if (mul_done) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= dens.value;
            m_tuser    <= dens.sat | sat_seen;
            kernel_sum <= '0;
            run_open   <= 1'b0;
            sat_seen   <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/spdn_checker.sv
// Port-level checks on the density core
module spdn_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [spdn_pkg::OUT_WIDTH-1:0]  m_tdata,
  input logic                            m_tuser
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // one item at a time: no back-to-back input beats
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while previous item in flight");

  // a result only appears at the end of a product, never out of idle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result beat without work in flight");

endmodule

bind sph_poly6_density_sum_core spdn_checker u_spdn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### test/sph_poly6_density_sum_core_tb.sv
`timescale 1ns / 1ps

module sph_poly6_density_sum_core_tb;
  import spdn_pkg::*;

  localparam int          SETTLE_CYCLES = 400;   // worst item: self term + neighbor + density
  localparam logic [63:0] ACC_LIMIT     = 64'((64'd1 << ACC_WIDTH) - 1);
  localparam logic [63:0] X_LIMIT       = 64'h0000_0000_FFFF_FFFF;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  localparam logic [H2_WIDTH-1:0] H2_ONE     = 48'h0001_0000_0000;   // 1.0 in Q16.32
  localparam logic [H2_WIDTH-1:0] H2_QUARTER = 48'h0000_4000_0000;
  localparam logic [H2_WIDTH-1:0] H2_FOUR    = 48'h0004_0000_0000;
  localparam logic [H2_WIDTH-1:0] H2_TWO     = 48'h0002_0000_0000;

  // product truncated to Q.24 plus overflow flag
  typedef struct packed {
    logic [63:0] val;
    logic        ovf;
  } fx_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] density;
    logic                 sat;
  } density_exp_t;

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [IN_DATA_WIDTH-1:0]   s_tdata;
  logic                       s_tuser;
  logic                       s_tlast;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [OUT_WIDTH-1:0]       m_tdata;
  logic                       m_tuser;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  sph_poly6_density_sum_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // dx, dy, dz
    .s_tuser   (s_tuser),    // skip
    .s_tlast   (s_tlast),    // last neighbor of particle
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // density
    .m_tuser   (m_tuser),    // saturated
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: register shadows plus the open-run accumulator
  logic [63:0]  r_h2;
  logic [63:0]  r_coeff;
  logic [63:0]  r_mass;
  logic [63:0]  acc_sum;
  logic         run_active;
  logic         run_sat;
  density_exp_t density_q[$];

  bit idle_en;
  int hold_cycles;
  int err_count;
  int beats_sent;
  int runs_sent;
  int densities_checked;
  int sat_results;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Timeout guard
  initial begin
    #(64'd40_000_000);
    $error("timeout: %0d densities still expected", density_q.size());
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // (a*b) >> 24 over the full product, clipped at the accumulator max
  function automatic fx_t fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    fx_t          r;
    p     = {64'd0, a} * {64'd0, b};
    r.val = p[87:24];
    r.ovf = (p[127:88] != 0) || (p[87:24] > ACC_LIMIT);
    if (r.ovf) r.val = ACC_LIMIT;
    return r;
  endfunction

  // Exact square of a signed Q8.16 component; most negative maps to 2^23
  function automatic logic [63:0] comp_sq(input logic [COORD_WIDTH-1:0] c);
    logic [COORD_WIDTH-1:0] n;
    logic [63:0]            m;
    n = ~c + 1'b1;
    m = c[COORD_WIDTH-1] ? 64'(n) : 64'(c);
    return m * m;
  endfunction

  // coeff * x^3 with x = (h2 - d2) >> 8, zero when d2 is not inside the radius
  function automatic fx_t kernel_term(input logic [63:0] d2);
    logic [63:0] x;
    fx_t         p;
    fx_t         r;
    logic        ovf;
    r = '0;
    if (r_h2 <= d2) return r;
    x   = (r_h2 - d2) >> X_SHIFT;
    ovf = 1'b0;
    if (x > X_LIMIT) begin
      x   = X_LIMIT;
      ovf = 1'b1;
    end
    p     = fx_mul(x, x);
    ovf   = ovf | p.ovf;
    p     = fx_mul(p.val, x);
    ovf   = ovf | p.ovf;
    r     = fx_mul(r_coeff, p.val);
    r.ovf = r.ovf | ovf;
    return r;
  endfunction

  task automatic predict_density(input logic [COORD_WIDTH-1:0] dx, dy, dz,
                                 input logic skip, is_last);
    fx_t          k;
    density_exp_t e;
    // first beat of a run loads the self term
    if (!run_active) begin
      k          = kernel_term(64'd0);
      acc_sum    = k.val;
      run_sat    = k.ovf;
      run_active = 1'b1;
    end
    if (!skip) begin
      k = kernel_term(comp_sq(dx) + comp_sq(dy) + comp_sq(dz));
      if (k.ovf) run_sat = 1'b1;
      if (k.val > ACC_LIMIT - acc_sum) begin
        acc_sum = ACC_LIMIT;
        run_sat = 1'b1;
      end else begin
        acc_sum = acc_sum + k.val;
      end
    end
    if (is_last) begin
      k         = fx_mul(r_mass, acc_sum);
      e.density = k.val[OUT_WIDTH-1:0];
      e.sat     = k.ovf | run_sat;
      density_q.push_back(e);
      acc_sum    = '0;
      run_active = 1'b0;
      run_sat    = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one neighbor beat; valid stays up afterwards, so it only drops in a random
  // idle gap before the next beat or when settle() lowers it.
  task automatic send_neighbor(input logic [COORD_WIDTH-1:0] dx, dy, dz,
                               input logic skip, is_last);
    int gap;
    if (idle_en && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_WIDTH'({dz, dy, dx});
    s_tuser  <= skip;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    predict_density(dx, dy, dz, skip, is_last);
    beats_sent++;
    if (is_last) runs_sent++;
  endtask

  // One register write; caller lowers cfg_valid when done
  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_H_SQUARED:     r_h2    = 64'(data[H2_WIDTH-1:0]);
      REG_KERNEL_COEFF:  r_coeff = 64'(data[COEFF_WIDTH-1:0]);
      REG_PARTICLE_MASS: r_mass  = 64'(data[MASS_WIDTH-1:0]);
      default: ;  // unmapped index is dropped
    endcase
  endtask

  // Wait for the block to drain and go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (density_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Upper cfg_data bits carry junk on the 32-bit registers
  task automatic program_regs(input logic [H2_WIDTH-1:0] h2,
                              input logic [COEFF_WIDTH-1:0] coeff,
                              input logic [MASS_WIDTH-1:0] mass);
    settle();
    cfg_write(REG_H_SQUARED, h2);
    cfg_write(REG_KERNEL_COEFF, {16'($urandom), coeff});
    cfg_write(REG_PARTICLE_MASS, {16'($urandom), mass});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [COORD_WIDTH-1:0] rand_coord(input int span);
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 10) return COORD_WIDTH'($urandom);
    if (pick < 14) begin
      case ($urandom_range(0, 2))
        0:       return 24'h800000;
        1:       return 24'h7FFFFF;
        default: return '0;
      endcase
    end
    v = int'($urandom_range(0, 2 * span)) - span;
    if (v > 8388607) v = 8388607;
    return COORD_WIDTH'(v);
  endfunction

  // Particle runs of 1..8 beats; a skipped self entry often opens the run
  task automatic run_random(input int n_items, input int span);
    int   left;
    int   len;
    logic skip;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 8);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        skip = (k == 0) ? ($urandom_range(0, 99) < 40) : ($urandom_range(0, 99) < 8);
        send_neighbor(rand_coord(span), rand_coord(span), rand_coord(span), skip,
                      k == len - 1);
      end
      left -= len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, with a counted hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else if (!idle_en) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // Result checker: each density beat against the oldest expectation
  always @(posedge clk) begin : density_check
    density_exp_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (density_q.size() == 0) begin
        err_count++;
        $error("unexpected density beat: density %h saturated %b", m_tdata, m_tuser);
      end else begin
        e = density_q.pop_front();
        densities_checked++;
        if (e.sat) sat_results++;
        if (m_tdata !== e.density) begin
          err_count++;
          $error("density mismatch: expected %h, actual %h", e.density, m_tdata);
        end
        if (m_tuser !== e.sat) begin
          err_count++;
          $error("saturated mismatch: expected %b, actual %b", e.sat, m_tuser);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: self-only run, d = 0, radius boundary, coordinate extremes
  task automatic test_defaults();
    send_neighbor('0, '0, '0, 1'b1, 1'b1);            // single beat, self term only
    send_neighbor('0, '0, '0, 1'b0, 1'b1);            // single beat plus own term
    send_neighbor('0, '0, '0, 1'b1, 1'b0);            // skipped self entry opens run
    send_neighbor(24'd65536, '0, '0, 1'b0, 1'b0);     // exactly on radius: x = 0
    send_neighbor(-24'sd65536, '0, '0, 1'b0, 1'b0);
    send_neighbor('0, 24'd65535, '0, 1'b0, 1'b0);     // just inside
    send_neighbor('0, '0, 24'h800000, 1'b0, 1'b0);    // most negative component
    send_neighbor(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0);
    send_neighbor(24'd32768, -24'sd32768, 24'd16384, 1'b0, 1'b1);
  endtask

  // h2 = 0: self term and every neighbor term vanish
  task automatic test_zero_radius();
    program_regs('0, COEFF_RESET, MASS_RESET);
    send_neighbor('0, '0, '0, 1'b0, 1'b1);
    send_neighbor('0, '0, '0, 1'b1, 1'b0);
    send_neighbor(24'd1, '0, '0, 1'b0, 1'b1);
  endtask

  // x narrowing, product, sum and density saturation
  task automatic test_saturation();
    program_regs('1, '1, '1);
    send_neighbor('0, '0, '0, 1'b1, 1'b1);
    send_neighbor(24'd100, '0, '0, 1'b0, 1'b1);
    program_regs(H2_ONE, COEFF_RESET, '1);            // mass at maximum, other registers nominal
    send_neighbor('0, '0, '0, 1'b0, 1'b1);
  endtask

  // Write to an unmapped index must leave every register unchanged
  task automatic test_unused_index();
    program_regs(H2_ONE, COEFF_RESET, MASS_RESET);
    cfg_write(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_neighbor('0, '0, '0, 1'b0, 1'b1);
  endtask

  task automatic test_random_default();
    program_regs(H2_RESET, COEFF_RESET, MASS_RESET);
    run_random(450, 65536);
  endtask

  // Both sides fully busy, no idling
  task automatic test_random_no_idle();
    program_regs(H2_QUARTER, 32'($urandom), 32'($urandom));
    idle_en = 1'b0;
    run_random(250, 32768);
    settle();
    idle_en = 1'b1;
  endtask

  task automatic test_random_wide_radius();
    program_regs(H2_FOUR, 32'($urandom_range(0, 32'h03FF_FFFF)), 32'h0080_0000);
    run_random(250, 131072);
  endtask

  task automatic test_random_registers();
    program_regs(48'({$urandom, $urandom}), 32'($urandom), 32'($urandom));
    run_random(200, 8388608);
  endtask

  task automatic test_random_saturating();
    program_regs('1, '1, '1);
    run_random(150, 8388608);
  endtask

  // Zero coefficient, then zero mass
  task automatic test_zero_scale();
    program_regs(H2_ONE, '0, '1);
    run_random(60, 65536);
    program_regs(H2_TWO, '1, '0);
    run_random(60, 92682);
  endtask

  // Receiver stalls for a long stretch while beats keep coming
  task automatic test_backpressure();
    program_regs(H2_RESET, COEFF_RESET, MASS_RESET);
    hold_cycles = 2500;
    for (int k = 0; k < 10; k++) begin
      send_neighbor(rand_coord(65536), rand_coord(65536), rand_coord(65536),
                    k[0] ^ k[1], k[0]);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    idle_en           = 1'b1;
    hold_cycles       = 0;
    err_count         = 0;
    beats_sent        = 0;
    runs_sent         = 0;
    densities_checked = 0;
    sat_results       = 0;
    r_h2       = 64'(H2_RESET);
    r_coeff    = 64'(COEFF_RESET);
    r_mass     = 64'(MASS_RESET);
    acc_sum    = '0;
    run_active = 1'b0;
    run_sat    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_zero_radius();
    test_saturation();
    test_unused_index();
    test_random_default();
    test_random_no_idle();
    test_random_wide_radius();
    test_random_registers();
    test_random_saturating();
    test_zero_scale();
    test_backpressure();
    settle();

    $display("Sent %0d neighbor beats in %0d particle runs under reset and reprogrammed registers.",
             beats_sent, runs_sent);
    $display("Checked %0d densities, %0d flagged saturated; %0d mismatches.",
             densities_checked, sat_results, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
